// ----- design/fjr_pkg.sv -----
// shared types, register indexes and reset values for the feeder jam recovery machine
`default_nettype none

package fjr_pkg;

  // feeder modes, encoded as on the mode output
  typedef enum logic [2:0] {
    MODE_STOP  = 3'd0,
    MODE_LOAD  = 3'd1,
    MODE_READY = 3'd2,
    MODE_FIRE  = 3'd3,
    MODE_UNJAM = 3'd4
  } mode_e;

  // lever positions that matter
  localparam logic [1:0] SwUp   = 2'd0;
  localparam logic [1:0] SwDown = 2'd2;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_START_KEY_MASK    = 3'd0,
    REG_HOLD_LIMIT        = 3'd1,
    REG_MIN_TRIGGER_SPEED = 3'd2,
    REG_LOW_SPEED_LIMIT   = 3'd3,
    REG_LOAD_TIME_LIMIT   = 3'd4,
    REG_FIRE_TIME_LIMIT   = 3'd5,
    REG_UNJAM_TIME_LIMIT  = 3'd6
  } reg_idx_e;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  // reset values of the configuration registers
  localparam logic [15:0] StartKeyMaskRst    = 16'd0;
  localparam logic [15:0] HoldLimitRst       = 16'd100;
  localparam logic [6:0]  MinTriggerSpeedRst = 7'd5;
  localparam logic [15:0] LowSpeedLimitRst   = 16'd100;
  localparam logic [15:0] LoadTimeLimitRst   = 16'd500;
  localparam logic [15:0] FireTimeLimitRst   = 16'd500;
  localparam logic [15:0] UnjamTimeLimitRst  = 16'd200;

  // default sizes
  localparam int unsigned TimerWidthDef = 16;
  localparam int unsigned PendingMaxDef = 255;

endpackage

`default_nettype wire

// ----- design/feeder_jam_recovery_fsm_top.sv -----
// feeder jam recovery mode machine, one control tick per request
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------------
//  in      | sink      | in_valid_i / in_ready_o   | switch_pos, keyboard, mouse_left,
//          |           |                           | feed_sensor, trigger_speed, trigger_cmd_nonzero
//  out     | source    | out_valid_o / out_ready_i | mode, aim_laser, pending_shots
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index, cfg_data
//
// one request is taken per clock while the result is drained; the whole tick is evaluated in the cycle it is
// accepted and the result sits in the output register from the next cycle on
// the output register is the only stage, so a request is taken whenever that
// register is empty or being drained in the same cycle
// reset clears mode, edge history, counters and timers and loads the configuration reset values; no clearing pass
// cfg writes are always taken (cfg_ready_o tied high); index seven is dropped
`default_nettype none

module feeder_jam_recovery_fsm_top
  import fjr_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TimerWidthDef,
  parameter int unsigned PENDING_MAX = PendingMaxDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // tick request
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [1:0]              switch_pos_i,
  input  wire logic [15:0]             keyboard_i,
  input  wire logic                    mouse_left_i,
  input  wire logic                    feed_sensor_i,
  input  wire logic signed [15:0]      trigger_speed_i,
  input  wire logic                    trigger_cmd_nonzero_i,
  // result
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [2:0]                   mode_o,
  output logic                         aim_laser_o,
  output logic [7:0]                   pending_shots_o,
  // configuration writes
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i
);

  localparam int unsigned PendW = $clog2(PENDING_MAX + 1);
  localparam int unsigned CmpW  = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam logic [PendW-1:0]       PendTop  = PendW'(PENDING_MAX);
  localparam logic [TIMER_WIDTH-1:0] TimerTop = '1;

  // configuration
  logic [15:0] start_key_mask_q, hold_limit_q, low_speed_limit_q;
  logic [15:0] load_time_limit_q, fire_time_limit_q, unjam_time_limit_q;
  logic [6:0]  min_trigger_speed_q;

  // tick state
  mode_e                   mode_q, mode_d;
  logic [1:0]              prev_switch_q;
  logic                    prev_key_hit_q, prev_mouse_q;
  logic [15:0]             hold_q, hold_d;
  logic [15:0]             slow_q, slow_d;
  logic [PendW-1:0]        pend_q, pend_d;
  logic [TIMER_WIDTH-1:0]  fire_tmr_q, fire_tmr_d;
  logic [TIMER_WIDTH-1:0]  unjam_tmr_q, unjam_tmr_d;
  logic [TIMER_WIDTH-1:0]  load_tmr_q, load_tmr_d;

  // result register
  logic             out_valid_q;
  logic [2:0]       out_mode_q;
  logic             out_laser_q;
  logic [7:0]       out_pend_q;

  logic in_acc, cfg_acc;

  // decoded tick
  logic             key_hit, toggle, active, held, once, force_one, slow_cond, stall;
  logic [16:0]      mag;
  logic [15:0]      hold_nx;
  logic [PendW-1:0] pend_edge;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // ---------------------------------------------------------------- request decode
  assign key_hit = |(keyboard_i & start_key_mask_q);
  // start/stop: lever moved to up, or masked key pressed
  assign toggle  = ((switch_pos_i == SwUp) && (prev_switch_q != SwUp)) ||
                   (key_hit && !prev_key_hit_q);
  // hold, pending and stall logic only run in a running mode with no start/stop
  assign active  = (mode_q != MODE_STOP) && !toggle;

  assign held = (switch_pos_i == SwDown) || mouse_left_i;
  assign once = ((switch_pos_i == SwDown) && (prev_switch_q != SwDown)) ||
                (mouse_left_i && !prev_mouse_q);

  // saturating hold counter; reaching the limit forces one pending shot
  assign hold_nx   = !held ? 16'd0 :
                     (hold_q < hold_limit_q) ? hold_q + 16'd1 : hold_q;
  assign force_one = (hold_nx == hold_limit_q);

  always_comb begin
    pend_edge = pend_q;
    if (once && (pend_q < PendTop)) begin
      pend_edge = pend_q + PendW'(1);
    end
    if (force_one) begin
      pend_edge = PendW'(1);
    end
  end

  // speed magnitude, 32768 for the most negative code
  assign mag = trigger_speed_i[15] ? (17'h10000 - {1'b0, trigger_speed_i})
                                   : {1'b0, trigger_speed_i};
  assign slow_cond = (mag < {10'd0, min_trigger_speed_q}) && trigger_cmd_nonzero_i;
  // stall only once the slow counter has already reached its limit
  assign stall = slow_cond && !(slow_q < low_speed_limit_q);

  // ---------------------------------------------------------------- next mode
  always_comb begin
    mode_d = mode_q;
    if (mode_q == MODE_STOP) begin
      if (toggle) begin
        mode_d = feed_sensor_i ? MODE_READY : MODE_LOAD;
      end
    end else if (toggle) begin
      mode_d = MODE_STOP;
    end else begin
      case (mode_q)
        MODE_LOAD: begin
          if (feed_sensor_i) begin
            mode_d = MODE_READY;
          end else if ((CmpW'(load_tmr_q) > CmpW'(load_time_limit_q)) && stall) begin
            mode_d = MODE_UNJAM;
          end
        end
        MODE_READY: begin
          if (pend_edge != '0) begin
            mode_d = MODE_FIRE;
          end
        end
        MODE_UNJAM: begin
          if (CmpW'(unjam_tmr_q) == CmpW'(unjam_time_limit_q)) begin
            mode_d = MODE_LOAD;
          end
        end
        MODE_FIRE: begin
          if (!feed_sensor_i) begin
            mode_d = MODE_LOAD;
          end
          // a stall past the fire timeout overrides the exit to load
          if ((CmpW'(fire_tmr_q) > CmpW'(fire_time_limit_q)) && stall) begin
            mode_d = MODE_UNJAM;
          end
        end
        default: mode_d = mode_q;
      endcase
    end
  end

  // ---------------------------------------------------------------- counters and timers
  always_comb begin
    hold_d = hold_q;
    slow_d = slow_q;
    pend_d = pend_q;
    if (active) begin
      hold_d = hold_nx;
      if (!slow_cond) begin
        slow_d = 16'd0;
      end else if (slow_q < low_speed_limit_q) begin
        slow_d = slow_q + 16'd1;
      end
      pend_d = pend_edge;
      // leaving fire for lack of a projectile spends one shot, even if unjam wins
      if ((mode_q == MODE_FIRE) && !feed_sensor_i && (pend_edge != '0)) begin
        pend_d = pend_edge - PendW'(1);
      end
    end
    if ((mode_d == MODE_STOP) && (mode_q != MODE_STOP)) begin
      pend_d = '0;
    end

    // each mode timer clears on entry and counts, saturating, while the mode stays
    fire_tmr_d  = fire_tmr_q;
    unjam_tmr_d = unjam_tmr_q;
    load_tmr_d  = load_tmr_q;
    if (mode_d == MODE_FIRE) begin
      fire_tmr_d = (mode_q != MODE_FIRE) ? '0 :
                   (fire_tmr_q == TimerTop) ? fire_tmr_q : fire_tmr_q + 1'b1;
    end
    if (mode_d == MODE_UNJAM) begin
      unjam_tmr_d = (mode_q != MODE_UNJAM) ? '0 :
                    (unjam_tmr_q == TimerTop) ? unjam_tmr_q : unjam_tmr_q + 1'b1;
    end
    if (mode_d == MODE_LOAD) begin
      load_tmr_d = (mode_q != MODE_LOAD) ? '0 :
                   (load_tmr_q == TimerTop) ? load_tmr_q : load_tmr_q + 1'b1;
    end
  end

  // ---------------------------------------------------------------- state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_STOP;
      prev_switch_q  <= 2'd0;
      prev_key_hit_q <= 1'b0;
      prev_mouse_q   <= 1'b0;
      hold_q         <= '0;
      slow_q         <= '0;
      pend_q         <= '0;
      fire_tmr_q     <= '0;
      unjam_tmr_q    <= '0;
      load_tmr_q     <= '0;
    end else if (in_acc) begin
      mode_q         <= mode_d;
      prev_switch_q  <= switch_pos_i;
      prev_key_hit_q <= key_hit;
      prev_mouse_q   <= mouse_left_i;
      hold_q         <= hold_d;
      slow_q         <= slow_d;
      pend_q         <= pend_d;
      fire_tmr_q     <= fire_tmr_d;
      unjam_tmr_q    <= unjam_tmr_d;
      load_tmr_q     <= load_tmr_d;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_mode_q  <= mode_d;
      out_laser_q <= (mode_q != MODE_STOP);
      out_pend_q  <= 8'(pend_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mode_o          = out_mode_q;
  assign aim_laser_o     = out_laser_q;
  assign pending_shots_o = out_pend_q;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_key_mask_q    <= StartKeyMaskRst;
      hold_limit_q        <= HoldLimitRst;
      min_trigger_speed_q <= MinTriggerSpeedRst;
      low_speed_limit_q   <= LowSpeedLimitRst;
      load_time_limit_q   <= LoadTimeLimitRst;
      fire_time_limit_q   <= FireTimeLimitRst;
      unjam_time_limit_q  <= UnjamTimeLimitRst;
    end else if (cfg_acc) begin
      case (cfg_index_i)
        REG_START_KEY_MASK:    start_key_mask_q    <= cfg_data_i;
        REG_HOLD_LIMIT:        hold_limit_q        <= cfg_data_i;
        REG_MIN_TRIGGER_SPEED: min_trigger_speed_q <= cfg_data_i[6:0];
        REG_LOW_SPEED_LIMIT:   low_speed_limit_q   <= cfg_data_i;
        REG_LOAD_TIME_LIMIT:   load_time_limit_q   <= cfg_data_i;
        REG_FIRE_TIME_LIMIT:   fire_time_limit_q   <= cfg_data_i;
        REG_UNJAM_TIME_LIMIT:  unjam_time_limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- assertions
  // the result shows the mode the state register moved to
  a_out_mode_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (out_valid_o && (mode_o == mode_q)))
    else $error("result mode differs from state");

  // laser follows the mode held before the tick
  a_laser_prev_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (aim_laser_o == ($past(mode_q) != MODE_STOP)))
    else $error("laser does not follow previous mode");

  // entering stop clears the pending shots
  a_stop_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (mode_q != MODE_STOP) && toggle) |=> ((mode_q == MODE_STOP) && (pend_q == '0)))
    else $error("stop entry left pending shots");

  // unjam only leaves toward load or stop
  a_unjam_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (mode_q == MODE_UNJAM)) |=>
      ((mode_q == MODE_UNJAM) || (mode_q == MODE_LOAD) || (mode_q == MODE_STOP)))
    else $error("illegal exit from unjam");

endmodule

`default_nettype wire
